// File: design/sgi_pkg.sv
// shared constants for the segment intersection unit
package sgi_pkg;

    localparam int SGI_COORD_WIDTH = 16;
    localparam int SGI_FRAC_BITS   = 8;
    localparam int SGI_POINT_WIDTH = 32;

endpackage

// File: design/sgi_if.sv
// valid/ready channel interfaces for segment pairs and crossing results
interface sgi_in_if
    import sgi_pkg::*;
#(
    parameter int COORD_WIDTH = SGI_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_start_x;
    logic signed [COORD_WIDTH-1:0] a_start_y;
    logic signed [COORD_WIDTH-1:0] a_end_x;
    logic signed [COORD_WIDTH-1:0] a_end_y;
    logic signed [COORD_WIDTH-1:0] b_start_x;
    logic signed [COORD_WIDTH-1:0] b_start_y;
    logic signed [COORD_WIDTH-1:0] b_end_x;
    logic signed [COORD_WIDTH-1:0] b_end_y;

    modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                    b_start_x, b_start_y, b_end_x, b_end_y, input ready);
    modport sink   (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                    b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface sgi_out_if
    import sgi_pkg::*;
();
    logic                              valid;
    logic                              ready;
    logic                              crosses;
    logic                              lines_parallel;
    logic                              point_saturated;
    logic signed [SGI_POINT_WIDTH-1:0] cross_x;
    logic signed [SGI_POINT_WIDTH-1:0] cross_y;

    modport source (output valid, crosses, lines_parallel, point_saturated,
                    cross_x, cross_y, input ready);
    modport sink   (input valid, crosses, lines_parallel, point_saturated,
                    cross_x, cross_y, output ready);
endinterface

// File: design/segment_intersection_unit.sv
// segment intersection unit: crossing test and line crossing point, fully pipelined
//
//  channel  direction  word contents
//  -------  ---------  ----------------------------------------------------------
//  req      in         a/b start and end points, COORD_WIDTH-bit signed each
//  rsp      out        crosses, lines_parallel, point_saturated, cross_x, cross_y
//
// one word per cycle while rsp is not stalled; a word passes the arithmetic front end, then
// the 32 restoring divider stages (one quotient bit each) and then the output register
// rst_n clears only the valid bits; payload registers are not reset
// a stall on rsp freezes the whole pipeline in place, so nothing is lost or repeated
// req.ready is low only while a result is held in the output register and not taken
module segment_intersection_unit
    import sgi_pkg::*;
#(
    parameter int COORD_WIDTH = SGI_COORD_WIDTH,
    parameter int FRAC_BITS   = SGI_FRAC_BITS
)(
    input  logic      clk,
    input  logic      rst_n,
    sgi_in_if.sink    req,
    sgi_out_if.source rsp
);

    localparam int W    = COORD_WIDTH;
    localparam int DFW  = W + 1;
    localparam int PRW  = 2 * W + 2;
    localparam int ORW  = 2 * W + 3;
    localparam int CPW  = 2 * W;
    localparam int CW   = 2 * W + 1;
    localparam int DTW  = 2 * W + 3;
    localparam int NPW  = 3 * W + 2;
    localparam int NXW  = 3 * W + 3;
    localparam int NW   = NXW + FRAC_BITS;
    localparam int QW   = SGI_POINT_WIDTH;
    localparam int DW   = DTW;
    localparam int CMPW = NW + QW;
    localparam logic [QW-1:0] QMAX_POS = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] QMAX_NEG = {1'b1, {(QW-1){1'b0}}};

    logic adv;
    logic [5:0] pv_reg;
    logic [QW:0] dv_reg;
    logic out_vld_reg;

    assign adv       = !out_vld_reg || rsp.ready;
    assign req.ready = adv;

    // stage 1: edge vectors and raw coordinates
    logic signed [DFW-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic signed [DFW-1:0] e1x_reg, e1y_reg, e2x_reg, e2y_reg, f2x_reg, f2y_reg;
    logic signed [W-1:0]   ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    logic signed [W-1:0]   bx1_reg, by1_reg, bx2_reg, by2_reg;

    function automatic logic signed [DFW-1:0] dif(logic signed [W-1:0] p,
                                                  logic signed [W-1:0] q);
        return {p[W-1], p} - {q[W-1], q};
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg  <= dif(req.a_end_x, req.a_start_x);
            b1_reg  <= dif(req.a_end_y, req.a_start_y);
            a2_reg  <= dif(req.b_end_x, req.b_start_x);
            b2_reg  <= dif(req.b_end_y, req.b_start_y);
            e1x_reg <= dif(req.b_start_x, req.a_start_x);
            e1y_reg <= dif(req.b_start_y, req.a_start_y);
            e2x_reg <= dif(req.b_end_x, req.a_start_x);
            e2y_reg <= dif(req.b_end_y, req.a_start_y);
            f2x_reg <= dif(req.a_end_x, req.b_start_x);
            f2y_reg <= dif(req.a_end_y, req.b_start_y);
            ax1_reg <= req.a_start_x;
            ay1_reg <= req.a_start_y;
            ax2_reg <= req.a_end_x;
            ay2_reg <= req.a_end_y;
            bx1_reg <= req.b_start_x;
            by1_reg <= req.b_start_y;
            bx2_reg <= req.b_end_x;
            by2_reg <= req.b_end_y;
        end
    end

    // stage 2: all first-level products
    logic signed [PRW-1:0] o1a_reg, o1b_reg, o2a_reg, o2b_reg;
    logic signed [PRW-1:0] o3a_reg, o3b_reg, o4a_reg, o4b_reg, da_reg, db_reg;
    logic signed [CPW-1:0] c1a_reg, c1b_reg, c2a_reg, c2b_reg;
    logic signed [DFW-1:0] a1_s2_reg, b1_s2_reg, a2_s2_reg, b2_s2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o1a_reg   <= a1_reg * e1y_reg;
            o1b_reg   <= b1_reg * e1x_reg;
            o2a_reg   <= a1_reg * e2y_reg;
            o2b_reg   <= b1_reg * e2x_reg;
            o3a_reg   <= b2_reg * e1x_reg;
            o3b_reg   <= a2_reg * e1y_reg;
            o4a_reg   <= a2_reg * f2y_reg;
            o4b_reg   <= b2_reg * f2x_reg;
            da_reg    <= a1_reg * b2_reg;
            db_reg    <= a2_reg * b1_reg;
            c1a_reg   <= ax2_reg * ay1_reg;
            c1b_reg   <= ax1_reg * ay2_reg;
            c2a_reg   <= bx2_reg * by1_reg;
            c2b_reg   <= bx1_reg * by2_reg;
            a1_s2_reg <= a1_reg;
            b1_s2_reg <= b1_reg;
            a2_s2_reg <= a2_reg;
            b2_s2_reg <= b2_reg;
        end
    end

    // stage 3: orientations, determinant, line constants
    logic signed [ORW-1:0] o1, o2, o3, o4;
    logic                  crosses_s3;
    logic signed [DTW-1:0] det_s3_reg;
    logic signed [CW-1:0]  c1_reg, c2_reg;
    logic                  crosses_s3_reg;
    logic signed [DFW-1:0] a1_s3_reg, b1_s3_reg, a2_s3_reg, b2_s3_reg;

    always_comb
    begin
        o1 = {o1a_reg[PRW-1], o1a_reg} - {o1b_reg[PRW-1], o1b_reg};
        o2 = {o2a_reg[PRW-1], o2a_reg} - {o2b_reg[PRW-1], o2b_reg};
        o3 = {o3a_reg[PRW-1], o3a_reg} - {o3b_reg[PRW-1], o3b_reg};
        o4 = {o4a_reg[PRW-1], o4a_reg} - {o4b_reg[PRW-1], o4b_reg};
        crosses_s3 = (o1 != '0) && (o2 != '0) && (o3 != '0) && (o4 != '0)
                     && (o1[ORW-1] != o2[ORW-1]) && (o3[ORW-1] != o4[ORW-1]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_s3_reg     <= {da_reg[PRW-1], da_reg} - {db_reg[PRW-1], db_reg};
            c1_reg         <= {c1a_reg[CPW-1], c1a_reg} - {c1b_reg[CPW-1], c1b_reg};
            c2_reg         <= {c2a_reg[CPW-1], c2a_reg} - {c2b_reg[CPW-1], c2b_reg};
            crosses_s3_reg <= crosses_s3;
            a1_s3_reg      <= a1_s2_reg;
            b1_s3_reg      <= b1_s2_reg;
            a2_s3_reg      <= a2_s2_reg;
            b2_s3_reg      <= b2_s2_reg;
        end
    end

    // stage 4: numerator products
    logic signed [NPW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [DTW-1:0] det_s4_reg;
    logic                  crosses_s4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg         <= a2_s3_reg * c1_reg;
            m2_reg         <= a1_s3_reg * c2_reg;
            m3_reg         <= b2_s3_reg * c1_reg;
            m4_reg         <= b1_s3_reg * c2_reg;
            det_s4_reg     <= det_s3_reg;
            crosses_s4_reg <= crosses_s3_reg;
        end
    end

    // stage 5: numerators
    logic signed [NXW-1:0] nx_reg, ny_reg;
    logic signed [DTW-1:0] det_s5_reg;
    logic                  crosses_s5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg         <= {m1_reg[NPW-1], m1_reg} - {m2_reg[NPW-1], m2_reg};
            ny_reg         <= {m3_reg[NPW-1], m3_reg} - {m4_reg[NPW-1], m4_reg};
            det_s5_reg     <= det_s4_reg;
            crosses_s5_reg <= crosses_s4_reg;
        end
    end

    // stage 6: magnitudes and fraction shift
    logic [NXW-1:0] nx_abs, ny_abs;
    logic [DW-1:0]  d_abs;
    logic [NW-1:0]  nxm_reg, nym_reg;
    logic [DW-1:0]  dm_s6_reg;
    logic           nxneg_reg, nyneg_reg, dneg_reg, par_s6_reg, crosses_s6_reg;

    always_comb
    begin
        nx_abs = nx_reg[NXW-1] ? NXW'(-nx_reg) : NXW'(nx_reg);
        ny_abs = ny_reg[NXW-1] ? NXW'(-ny_reg) : NXW'(ny_reg);
        d_abs  = det_s5_reg[DTW-1] ? DW'(-det_s5_reg) : DW'(det_s5_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nxm_reg        <= NW'(nx_abs) << FRAC_BITS;
            nym_reg        <= NW'(ny_abs) << FRAC_BITS;
            dm_s6_reg      <= d_abs;
            nxneg_reg      <= nx_reg[NXW-1];
            nyneg_reg      <= ny_reg[NXW-1];
            dneg_reg       <= det_s5_reg[DTW-1];
            par_s6_reg     <= (det_s5_reg == '0);
            crosses_s6_reg <= crosses_s5_reg;
        end
    end

    // divider: lane 0 is x, lane 1 is y; entry 0 is the setup stage
    logic [DW-1:0] rem_reg   [0:1][0:QW];
    logic [QW-1:0] low_reg   [0:1][0:QW];
    logic [QW-1:0] quo_reg   [0:1][0:QW];
    logic          neg_reg   [0:1][0:QW];
    logic          big_reg   [0:1][0:QW];
    logic [DW-1:0] dm_reg    [0:QW];
    logic          par_reg   [0:QW];
    logic          crs_reg   [0:QW];
    logic [CMPW-1:0] npad [0:1];
    logic [CMPW-1:0] dpad;

    always_comb
    begin
        npad[0] = CMPW'(nxm_reg);
        npad[1] = CMPW'(nym_reg);
        dpad    = CMPW'(dm_s6_reg) << QW;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0][0] <= npad[0][QW +: DW];
            low_reg[0][0] <= npad[0][QW-1:0];
            quo_reg[0][0] <= '0;
            // quotient would not fit the output word at all
            big_reg[0][0] <= (npad[0] >= dpad);
            rem_reg[1][0] <= npad[1][QW +: DW];
            low_reg[1][0] <= npad[1][QW-1:0];
            quo_reg[1][0] <= '0;
            big_reg[1][0] <= (npad[1] >= dpad);
            neg_reg[0][0] <= nxneg_reg ^ dneg_reg;
            neg_reg[1][0] <= nyneg_reg ^ dneg_reg;
            dm_reg[0]     <= dm_s6_reg;
            par_reg[0]    <= par_s6_reg;
            crs_reg[0]    <= crosses_s6_reg;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_div
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [DW:0] trial;
            logic        ge;

            always_comb
            begin
                trial = {rem_reg[l][k-1], low_reg[l][k-1][QW-1]};
                ge    = trial >= {1'b0, dm_reg[k-1]};
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[l][k] <= ge ? DW'(trial - {1'b0, dm_reg[k-1]}) : trial[DW-1:0];
                    low_reg[l][k] <= low_reg[l][k-1] << 1;
                    quo_reg[l][k] <= {quo_reg[l][k-1][QW-2:0], ge};
                    neg_reg[l][k] <= neg_reg[l][k-1];
                    big_reg[l][k] <= big_reg[l][k-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dm_reg[k]  <= dm_reg[k-1];
                par_reg[k] <= par_reg[k-1];
                crs_reg[k] <= crs_reg[k-1];
            end
        end
    end

    // output stage: sign, saturation, parallel override
    logic [QW-1:0] pt [0:1];
    logic          sat [0:1];
    logic          crosses_reg, par_reg_out, sat_reg;
    logic [QW-1:0] cx_reg, cy_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            sat[l] = big_reg[l][QW]
                     || (quo_reg[l][QW] > (neg_reg[l][QW] ? QMAX_NEG : QMAX_POS));
            if (sat[l])
                pt[l] = neg_reg[l][QW] ? QMAX_NEG : QMAX_POS;
            else
                pt[l] = neg_reg[l][QW] ? QW'(-quo_reg[l][QW]) : quo_reg[l][QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            crosses_reg <= crs_reg[QW];
            par_reg_out <= par_reg[QW];
            sat_reg     <= !par_reg[QW] && (sat[0] || sat[1]);
            cx_reg      <= par_reg[QW] ? '0 : pt[0];
            cy_reg      <= par_reg[QW] ? '0 : pt[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg      <= '0;
            dv_reg      <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            pv_reg      <= {pv_reg[4:0], req.valid};
            dv_reg      <= {dv_reg[QW-1:0], pv_reg[5]};
            out_vld_reg <= dv_reg[QW];
        end
    end

    assign rsp.valid           = out_vld_reg;
    assign rsp.crosses         = crosses_reg;
    assign rsp.lines_parallel  = par_reg_out;
    assign rsp.point_saturated = sat_reg;
    assign rsp.cross_x         = cx_reg;
    assign rsp.cross_y         = cy_reg;

endmodule

// File: design/sgi_checker.sv
// port-level checks for the segment intersection unit, bound to the top level
module sgi_checker
    import sgi_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic                       crosses,
    input logic                       lines_parallel,
    input logic                       point_saturated,
    input logic [SGI_POINT_WIDTH-1:0] cross_x,
    input logic [SGI_POINT_WIDTH-1:0] cross_y
);

    localparam logic [SGI_POINT_WIDTH-1:0] PMAX = {1'b0, {(SGI_POINT_WIDTH-1){1'b1}}};
    localparam logic [SGI_POINT_WIDTH-1:0] PMIN = {1'b1, {(SGI_POINT_WIDTH-1){1'b0}}};

    // parallel lines carry a zero point and no clamp
    a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && lines_parallel |-> cross_x == '0 && cross_y == '0 && !point_saturated)
        else $error("parallel result with nonzero point");

    // a proper crossing needs a nonzero determinant
    a_cross_not_par: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && crosses |-> !lines_parallel)
        else $error("crossing reported on parallel lines");

    // a clamp shows up as a range limit in some coordinate
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && point_saturated |-> cross_x == PMAX || cross_x == PMIN
                                         || cross_y == PMAX || cross_y == PMIN)
        else $error("saturation flag without a clamped coordinate");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(cross_x) && $stable(cross_y))
        else $error("result word dropped or changed while stalled");

endmodule

bind segment_intersection_unit sgi_checker u_sgi_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .crosses         (rsp.crosses),
    .lines_parallel  (rsp.lines_parallel),
    .point_saturated (rsp.point_saturated),
    .cross_x         (rsp.cross_x),
    .cross_y         (rsp.cross_y)
);
